### hw/rtl/ubxnav_pkg.sv
// Shared types and constants for the UBX navigation frame parser.
// No dependencies; every other RTL file imports this package.
`default_nettype none

package ubxnav_pkg;

    // Protocol constants.
    localparam logic [7:0] SYNC_A    = 8'hB5;
    localparam logic [7:0] SYNC_B    = 8'h62;
    localparam logic [7:0] CLS_NAV   = 8'h01;
    localparam logic [7:0] ID_POSLLH = 8'h02;
    localparam logic [7:0] ID_STATUS = 8'h03;
    localparam logic [7:0] ID_VELNED = 8'h12;

    localparam logic [15:0] TIMEOUT_RESET = 16'd5000;

    // Input word operation codes.
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // Configuration register indexes.
    localparam logic [7:0] CFG_TIMEOUT_TICKS     = 8'd0;
    localparam logic [7:0] CFG_CORRECTION_ENABLE = 8'd1;
    localparam logic [7:0] CFG_LAT_OFFSET        = 8'd2;
    localparam logic [7:0] CFG_LON_OFFSET        = 8'd3;

    // Slots of the pending and reported field stores.
    localparam int          NUM_SLOTS = 6;
    localparam logic [2:0]  SLOT_LAT  = 3'd0;
    localparam logic [2:0]  SLOT_LON  = 3'd1;
    localparam logic [2:0]  SLOT_ALT  = 3'd2;
    localparam logic [2:0]  SLOT_VN   = 3'd3;
    localparam logic [2:0]  SLOT_VE   = 3'd4;
    localparam logic [2:0]  SLOT_HDG  = 3'd5;

    typedef struct packed {
        logic       operation;
        logic [7:0] rx_byte;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] latitude;
        logic signed [31:0] longitude;
        logic signed [31:0] altitude;
        logic signed [31:0] north_velocity;
        logic signed [31:0] east_velocity;
        logic signed [31:0] heading;
        logic        [7:0]  fix_type;
        logic               has_position;
        logic               connected;
        logic               frame_done;
        logic               sync_error;
    } out_item_t;

    // Capture controls from the frame sequencer to the field store.
    typedef struct packed {
        logic       byte_en;     // payload byte goes into the word assembler
        logic [1:0] lane;        // byte lane within the little-endian word
        logic       slot_we;     // completed word is a wanted field
        logic [2:0] slot;
        logic       fix_we;      // this byte is the fix type
        logic       commit;      // last byte of the frame
        logic       clear_mask;  // new frame after a good sync pair
    } cap_ctrl_t;

    // Reported values after the current step.
    typedef struct packed {
        logic [31:0] lat;
        logic [31:0] lon;
        logic [31:0] alt;
        logic [31:0] vn;
        logic [31:0] ve;
        logic [31:0] hdg;
        logic [7:0]  fix;
        logic        has_position;
    } report_t;

endpackage

`default_nettype wire

### hw/rtl/ubxnav_fields.sv
// Field store of the UBX parser: word assembler, pending fields and the
// reported fields committed at the end of each frame. Depends on ubxnav_pkg.
`default_nettype none

module ubxnav_fields (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire ubxnav_pkg::cap_ctrl_t ctrl,
    input  wire logic [7:0]            rx_byte,
    output ubxnav_pkg::report_t        report
);
    import ubxnav_pkg::*;

    logic [31:0] asm_reg, asm_next;
    logic [31:0] pending_reg [NUM_SLOTS];
    logic [31:0] pending_next [NUM_SLOTS];
    logic [7:0]  pending_fix_reg, pending_fix_next;
    logic [NUM_SLOTS:0] mask_reg, mask_next;   // top bit marks the fix type
    logic [31:0] reported_reg [NUM_SLOTS];
    logic [31:0] reported_next [NUM_SLOTS];
    logic [7:0]  reported_fix_reg, reported_fix_next;
    logic        position_reg, position_next;

    always_comb
    begin
        asm_next          = asm_reg;
        pending_next      = pending_reg;
        pending_fix_next  = pending_fix_reg;
        mask_next         = mask_reg;
        reported_next     = reported_reg;
        reported_fix_next = reported_fix_reg;
        position_next     = position_reg;

        if (ctrl.byte_en)
        begin
            case (ctrl.lane)
                2'd0:    asm_next = {24'd0, rx_byte};
                2'd1:    asm_next = asm_reg | {16'd0, rx_byte, 8'd0};
                2'd2:    asm_next = asm_reg | {8'd0, rx_byte, 16'd0};
                2'd3:    asm_next = asm_reg | {rx_byte, 24'd0};
                default: asm_next = asm_reg;
            endcase
        end

        if (ctrl.slot_we)
        begin
            pending_next[ctrl.slot] = asm_next;
            mask_next[ctrl.slot]    = 1'b1;
        end

        if (ctrl.fix_we)
        begin
            pending_fix_next     = rx_byte;
            mask_next[NUM_SLOTS] = 1'b1;
        end

        if (ctrl.commit)
        begin
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                if (mask_next[i])
                begin
                    reported_next[i] = pending_next[i];
                end
            end
            if (mask_next[NUM_SLOTS])
            begin
                reported_fix_next = pending_fix_next;
            end
            if (mask_next[SLOT_ALT])
            begin
                position_next = 1'b1;
            end
            mask_next = '0;
        end

        if (ctrl.clear_mask)
        begin
            mask_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            asm_reg          <= '0;
            mask_reg         <= '0;
            pending_fix_reg  <= '0;
            reported_fix_reg <= '0;
            position_reg     <= 1'b0;
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                reported_reg[i] <= '0;
            end
        end
        else
        begin
            asm_reg          <= asm_next;
            mask_reg         <= mask_next;
            pending_fix_reg  <= pending_fix_next;
            reported_fix_reg <= reported_fix_next;
            position_reg     <= position_next;
            reported_reg     <= reported_next;
        end
    end

    // Pending words are only read once their mask bit is set, so they need no reset.
    always_ff @(posedge clk)
    begin
        pending_reg <= pending_next;
    end

    always_comb
    begin
        report.lat          = reported_next[SLOT_LAT];
        report.lon          = reported_next[SLOT_LON];
        report.alt          = reported_next[SLOT_ALT];
        report.vn           = reported_next[SLOT_VN];
        report.ve           = reported_next[SLOT_VE];
        report.hdg          = reported_next[SLOT_HDG];
        report.fix          = reported_fix_next;
        report.has_position = position_next;
    end

endmodule

`default_nettype wire

### hw/rtl/ubx_nav_frame_parser_core.sv
// Top level of the UBX navigation frame parser: frame sequencer, link timeout,
// configuration registers and result register. Depends on ubxnav_pkg, ubxnav_fields.
`default_nettype none

// How to use this block:
// The item channel (item_valid, item_ready, item) carries one word per
// accepted handshake: either a received serial byte or one timer tick.
// Every accepted word produces exactly one result word on the result
// channel (result_valid, result_ready, result), which shows the reported
// navigation fields, fix type and link status after that word, plus the
// frame_done and sync_error flags for that word.
// The result is registered at the edge that accepts the word and is valid
// in the following cycle. Throughput, while the receiver keeps up, is one
// word per cycle, set by the single pass through sequencer and field store.
// When the receiver stalls, the finished result holds in the result
// register, and a new word is accepted in the same cycle that result is
// taken, so the flow never stops while result_ready stays high.
// The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) is
// always ready; index 0 is the timeout reload, 1 the correction enable,
// 2 and 3 the latitude and longitude offsets. Write it only while idle.
// Reset hunts for the first sync byte, clears all reported fields, marks the
// link disconnected and restores the register defaults (timeout 5000).

module ubx_nav_frame_parser_core (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  item_valid,
    output logic                       item_ready,
    input  wire ubxnav_pkg::in_item_t  item,
    output logic                       result_valid,
    input  wire logic                  result_ready,
    output ubxnav_pkg::out_item_t      result,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [7:0]            cfg_index,
    input  wire logic [31:0]           cfg_data
);
    import ubxnav_pkg::*;

    typedef enum logic [6:0] {
        PH_SYNC1 = 7'b0000001,
        PH_SYNC2 = 7'b0000010,
        PH_CLASS = 7'b0000100,
        PH_ID    = 7'b0001000,
        PH_LEN1  = 7'b0010000,
        PH_LEN2  = 7'b0100000,
        PH_BODY  = 7'b1000000
    } phase_t;

    // Configuration registers.
    logic [15:0] timeout_ticks_reg;
    logic        correction_enable_reg;
    logic [31:0] lat_offset_reg;
    logic [31:0] lon_offset_reg;

    // Sequencer and link state.
    phase_t      phase_reg, phase_next;
    logic [16:0] byte_offset_reg, byte_offset_next;
    logic [16:0] frame_length_reg, frame_length_next;
    logic [7:0]  frame_class_reg, frame_class_next;
    logic [7:0]  frame_id_reg, frame_id_next;
    logic        link_up_reg, link_up_next;
    logic [15:0] timeout_count_reg, timeout_count_next;

    logic        result_valid_reg;
    out_item_t   result_reg, result_next;

    logic        accept;
    logic        done, serr;
    cap_ctrl_t   ctrl;
    report_t     report;

    logic [16:0] pay_pos;       // position within the payload
    logic        in_payload;
    logic        last_byte;
    logic        is_posllh, is_velned, is_status;
    logic [15:0] count_dec;

    assign item_ready = !result_valid_reg || result_ready;
    assign accept     = item_valid && item_ready;
    assign cfg_ready  = 1'b1;

    assign pay_pos    = byte_offset_reg - 17'd6;
    // Payload bytes end two bytes before the frame end (checksum).
    assign in_payload = ({1'b0, byte_offset_reg} + 18'd2) < {1'b0, frame_length_reg};
    assign last_byte  = ({1'b0, byte_offset_reg} + 18'd1) >= {1'b0, frame_length_reg};
    assign is_posllh  = (frame_class_reg == CLS_NAV) && (frame_id_reg == ID_POSLLH);
    assign is_velned  = (frame_class_reg == CLS_NAV) && (frame_id_reg == ID_VELNED);
    assign is_status  = (frame_class_reg == CLS_NAV) && (frame_id_reg == ID_STATUS);
    assign count_dec  = (timeout_count_reg != 16'd0) ? timeout_count_reg - 16'd1 : 16'd0;

    always_comb
    begin
        phase_next         = phase_reg;
        byte_offset_next   = byte_offset_reg;
        frame_length_next  = frame_length_reg;
        frame_class_next   = frame_class_reg;
        frame_id_next      = frame_id_reg;
        link_up_next       = link_up_reg;
        timeout_count_next = timeout_count_reg;
        ctrl               = '0;
        done               = 1'b0;
        serr               = 1'b0;

        if (accept)
        begin
            if (item.operation == OP_TICK)
            begin
                if (link_up_reg)
                begin
                    timeout_count_next = count_dec;
                    if (count_dec == 16'd0)
                    begin
                        link_up_next = 1'b0;
                    end
                end
            end
            else
            begin
                case (phase_reg)
                    PH_SYNC1:
                    begin
                        if (item.rx_byte == SYNC_A)
                        begin
                            phase_next       = PH_SYNC2;
                            byte_offset_next = 17'd1;
                        end
                        else
                        begin
                            serr = 1'b1;
                        end
                    end
                    PH_SYNC2:
                    begin
                        if (item.rx_byte == SYNC_B)
                        begin
                            link_up_next       = 1'b1;
                            timeout_count_next = timeout_ticks_reg;
                            ctrl.clear_mask    = 1'b1;
                            phase_next         = PH_CLASS;
                            byte_offset_next   = 17'd2;
                        end
                        else
                        begin
                            serr             = 1'b1;
                            phase_next       = PH_SYNC1;
                            byte_offset_next = 17'd0;
                        end
                    end
                    PH_CLASS:
                    begin
                        frame_class_next = item.rx_byte;
                        phase_next       = PH_ID;
                        byte_offset_next = 17'd3;
                    end
                    PH_ID:
                    begin
                        frame_id_next    = item.rx_byte;
                        phase_next       = PH_LEN1;
                        byte_offset_next = 17'd4;
                    end
                    PH_LEN1:
                    begin
                        frame_length_next = {9'd0, item.rx_byte};
                        phase_next        = PH_LEN2;
                        byte_offset_next  = 17'd5;
                    end
                    PH_LEN2:
                    begin
                        // Total frame length: header, payload and checksum.
                        frame_length_next = {1'b0, item.rx_byte, frame_length_reg[7:0]}
                                            + 17'd8;
                        phase_next        = PH_BODY;
                        byte_offset_next  = 17'd6;
                    end
                    PH_BODY:
                    begin
                        if (in_payload)
                        begin
                            ctrl.byte_en = 1'b1;
                            ctrl.lane    = pay_pos[1:0];
                            // A word completes on lane 3; match on its last byte.
                            if (is_posllh)
                            begin
                                if (pay_pos == 17'd7)
                                begin
                                    ctrl.slot_we = 1'b1;
                                    ctrl.slot    = SLOT_LON;
                                end
                                else if (pay_pos == 17'd11)
                                begin
                                    ctrl.slot_we = 1'b1;
                                    ctrl.slot    = SLOT_LAT;
                                end
                                else if (pay_pos == 17'd19)
                                begin
                                    ctrl.slot_we = 1'b1;
                                    ctrl.slot    = SLOT_ALT;
                                end
                            end
                            else if (is_velned)
                            begin
                                if (pay_pos == 17'd7)
                                begin
                                    ctrl.slot_we = 1'b1;
                                    ctrl.slot    = SLOT_VN;
                                end
                                else if (pay_pos == 17'd11)
                                begin
                                    ctrl.slot_we = 1'b1;
                                    ctrl.slot    = SLOT_VE;
                                end
                                else if (pay_pos == 17'd27)
                                begin
                                    ctrl.slot_we = 1'b1;
                                    ctrl.slot    = SLOT_HDG;
                                end
                            end
                            if (is_status && (pay_pos == 17'd4))
                            begin
                                ctrl.fix_we = 1'b1;
                            end
                        end
                        if (last_byte)
                        begin
                            ctrl.commit      = 1'b1;
                            done             = 1'b1;
                            phase_next       = PH_SYNC1;
                            byte_offset_next = 17'd0;
                        end
                        else
                        begin
                            byte_offset_next = byte_offset_reg + 17'd1;
                        end
                    end
                    default:
                    begin
                        phase_next       = PH_SYNC1;
                        byte_offset_next = 17'd0;
                    end
                endcase
            end
        end
    end

    ubxnav_fields u_fields (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (ctrl),
        .rx_byte (item.rx_byte),
        .report  (report)
    );

    // Result word after this step, with optional lat/lon correction.
    always_comb
    begin
        result_next.latitude       = correction_enable_reg ? report.lat - lat_offset_reg
                                                           : report.lat;
        result_next.longitude      = correction_enable_reg ? report.lon - lon_offset_reg
                                                           : report.lon;
        result_next.altitude       = report.alt;
        result_next.north_velocity = report.vn;
        result_next.east_velocity  = report.ve;
        result_next.heading        = report.hdg;
        result_next.fix_type       = report.fix;
        result_next.has_position   = report.has_position;
        result_next.connected      = link_up_next;
        result_next.frame_done     = done;
        result_next.sync_error     = serr;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_ticks_reg     <= TIMEOUT_RESET;
            correction_enable_reg <= 1'b0;
            lat_offset_reg        <= '0;
            lon_offset_reg        <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_TIMEOUT_TICKS:     timeout_ticks_reg     <= cfg_data[15:0];
                CFG_CORRECTION_ENABLE: correction_enable_reg <= cfg_data[0];
                CFG_LAT_OFFSET:        lat_offset_reg        <= cfg_data;
                CFG_LON_OFFSET:        lon_offset_reg        <= cfg_data;
                default:               ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_SYNC1;
            byte_offset_reg   <= '0;
            frame_length_reg  <= 17'd6;
            frame_class_reg   <= '0;
            frame_id_reg      <= '0;
            link_up_reg       <= 1'b0;
            timeout_count_reg <= '0;
            result_valid_reg  <= 1'b0;
        end
        else
        begin
            phase_reg         <= phase_next;
            byte_offset_reg   <= byte_offset_next;
            frame_length_reg  <= frame_length_next;
            frame_class_reg   <= frame_class_next;
            frame_id_reg      <= frame_id_next;
            link_up_reg       <= link_up_next;
            timeout_count_reg <= timeout_count_next;
            if (accept)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

`default_nettype wire

### dv/ubx_nav_frame_parser_checker.sv
// Checker for the UBX navigation frame parser: watches the item, result and register
// channels, predicts each result word and compares it field by field.
// Depends on ubxnav_pkg.
`timescale 1ns / 1ps

module ubx_nav_frame_parser_checker (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    input  logic                  item_ready,
    input  ubxnav_pkg::in_item_t  item,
    input  logic                  result_valid,
    input  logic                  result_ready,
    input  ubxnav_pkg::out_item_t result,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [7:0]            cfg_index,
    input  logic [31:0]           cfg_data,
    output int                    mismatches,
    output int                    awaiting,
    output int                    frames_seen,
    output int                    sync_errors_seen
);
    import ubxnav_pkg::*;

    typedef enum logic [6:0] {
        HUNT_A     = 7'b0000001,
        HUNT_B     = 7'b0000010,
        GET_CLASS  = 7'b0000100,
        GET_ID     = 7'b0001000,
        GET_LEN_LO = 7'b0010000,
        GET_LEN_HI = 7'b0100000,
        IN_BODY    = 7'b1000000
    } parse_state_t;

    // Bit of the pending mask that marks a captured fix type.
    localparam int FIX_FLAG = 6;

    // Register copies.
    logic [15:0] reload_ticks;
    logic        corr_on;
    logic [31:0] lat_shift;
    logic [31:0] lon_shift;

    // Parser copy.
    parse_state_t state;
    logic [16:0]  pos;
    logic [16:0]  frame_len;
    logic [7:0]   cls;
    logic [7:0]   id;
    logic [31:0]  word;
    logic [31:0]  pend [NUM_SLOTS];
    logic [7:0]   pend_fix;
    logic [6:0]   pend_mask;
    logic [31:0]  shown [NUM_SLOTS];
    logic [7:0]   shown_fix;
    logic         pos_known;
    logic         link;
    logic [15:0]  ticks_left;

    out_item_t expected_reports [$];

    task automatic advance_parser(input in_item_t w, output out_item_t r);
        logic [16:0] p;
        logic [16:0] woff;
        int          slot;
        int          i;
        logic        done;
        logic        serr;
        done = 1'b0;
        serr = 1'b0;
        if (w.operation == OP_TICK)
        begin
            if (link)
            begin
                if (ticks_left != 16'd0) ticks_left = ticks_left - 16'd1;
                if (ticks_left == 16'd0) link = 1'b0;
            end
        end
        else
        begin
            case (state)
                HUNT_A:
                begin
                    if (w.rx_byte == SYNC_A)
                    begin
                        state = HUNT_B;
                        pos = 17'd1;
                    end
                    else serr = 1'b1;
                end
                HUNT_B:
                begin
                    if (w.rx_byte == SYNC_B)
                    begin
                        link = 1'b1;
                        ticks_left = reload_ticks;
                        pend_mask = '0;
                        state = GET_CLASS;
                        pos = 17'd2;
                    end
                    else
                    begin
                        serr = 1'b1;
                        state = HUNT_A;
                        pos = 17'd0;
                    end
                end
                GET_CLASS:
                begin
                    cls = w.rx_byte;
                    state = GET_ID;
                    pos = 17'd3;
                end
                GET_ID:
                begin
                    id = w.rx_byte;
                    state = GET_LEN_LO;
                    pos = 17'd4;
                end
                GET_LEN_LO:
                begin
                    frame_len = {9'd0, w.rx_byte};
                    state = GET_LEN_HI;
                    pos = 17'd5;
                end
                GET_LEN_HI:
                begin
                    // Header and checksum bytes are counted in the frame length.
                    frame_len = {1'b0, w.rx_byte, frame_len[7:0]} + 17'd8;
                    state = IN_BODY;
                    pos = 17'd6;
                end
                default:
                begin
                    p = pos - 17'd6;
                    if (p < frame_len - 17'd8)
                    begin
                        if (p[1:0] == 2'd0) word = {24'd0, w.rx_byte};
                        else word = word | ({24'd0, w.rx_byte} << (8 * p[1:0]));
                        if (p[1:0] == 2'd3 && cls == CLS_NAV)
                        begin
                            woff = p - 17'd3;
                            slot = -1;
                            if (id == ID_POSLLH)
                            begin
                                if (woff == 17'd4) slot = SLOT_LON;
                                else if (woff == 17'd8) slot = SLOT_LAT;
                                else if (woff == 17'd16) slot = SLOT_ALT;
                            end
                            else if (id == ID_VELNED)
                            begin
                                if (woff == 17'd4) slot = SLOT_VN;
                                else if (woff == 17'd8) slot = SLOT_VE;
                                else if (woff == 17'd24) slot = SLOT_HDG;
                            end
                            if (slot >= 0)
                            begin
                                pend[slot] = word;
                                pend_mask[slot] = 1'b1;
                            end
                        end
                        if (cls == CLS_NAV && id == ID_STATUS && p == 17'd4)
                        begin
                            pend_fix = w.rx_byte;
                            pend_mask[FIX_FLAG] = 1'b1;
                        end
                    end
                    if (pos + 17'd1 >= frame_len)
                    begin
                        for (i = 0; i < NUM_SLOTS; i++)
                            if (pend_mask[i]) shown[i] = pend[i];
                        if (pend_mask[FIX_FLAG]) shown_fix = pend_fix;
                        if (pend_mask[SLOT_ALT]) pos_known = 1'b1;
                        pend_mask = '0;
                        done = 1'b1;
                        state = HUNT_A;
                        pos = 17'd0;
                    end
                    else pos = pos + 17'd1;
                end
            endcase
        end
        r.latitude       = corr_on ? shown[SLOT_LAT] - lat_shift : shown[SLOT_LAT];
        r.longitude      = corr_on ? shown[SLOT_LON] - lon_shift : shown[SLOT_LON];
        r.altitude       = shown[SLOT_ALT];
        r.north_velocity = shown[SLOT_VN];
        r.east_velocity  = shown[SLOT_VE];
        r.heading        = shown[SLOT_HDG];
        r.fix_type       = shown_fix;
        r.has_position   = pos_known;
        r.connected      = link;
        r.frame_done     = done;
        r.sync_error     = serr;
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %08h, got %08h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        out_item_t predicted;
        out_item_t want;
        if (!rst_n)
        begin
            reload_ticks = TIMEOUT_RESET;
            corr_on = 1'b0;
            lat_shift = '0;
            lon_shift = '0;
            state = HUNT_A;
            pos = '0;
            frame_len = 17'd6;
            cls = '0;
            id = '0;
            word = '0;
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                pend[i] = '0;
                shown[i] = '0;
            end
            pend_fix = '0;
            pend_mask = '0;
            shown_fix = '0;
            pos_known = 1'b0;
            link = 1'b0;
            ticks_left = '0;
            expected_reports.delete();
            mismatches = 0;
            awaiting = 0;
            frames_seen = 0;
            sync_errors_seen = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_TIMEOUT_TICKS:     reload_ticks = cfg_data[15:0];
                    CFG_CORRECTION_ENABLE: corr_on = cfg_data[0];
                    CFG_LAT_OFFSET:        lat_shift = cfg_data;
                    CFG_LON_OFFSET:        lon_shift = cfg_data;
                    default: ;
                endcase
            end
            // The result taken at this edge belongs to an earlier word, so it is
            // matched before the word accepted at this edge is predicted.
            if (result_valid && result_ready)
            begin
                if (expected_reports.size() == 0)
                begin
                    $error("result word arrived with no prediction waiting");
                    mismatches++;
                end
                else
                begin
                    want = expected_reports.pop_front();
                    check_field("latitude", want.latitude, result.latitude);
                    check_field("longitude", want.longitude, result.longitude);
                    check_field("altitude", want.altitude, result.altitude);
                    check_field("north_velocity", want.north_velocity,
                                result.north_velocity);
                    check_field("east_velocity", want.east_velocity, result.east_velocity);
                    check_field("heading", want.heading, result.heading);
                    check_field("fix_type", want.fix_type, result.fix_type);
                    check_field("has_position", want.has_position, result.has_position);
                    check_field("connected", want.connected, result.connected);
                    check_field("frame_done", want.frame_done, result.frame_done);
                    check_field("sync_error", want.sync_error, result.sync_error);
                end
                if (result.frame_done === 1'b1) frames_seen++;
                if (result.sync_error === 1'b1) sync_errors_seen++;
            end
            if (item_valid && item_ready)
            begin
                advance_parser(item, predicted);
                expected_reports.push_back(predicted);
            end
            awaiting = expected_reports.size();
        end
    end

endmodule

### dv/ubx_nav_frame_parser_core_test.sv
// Top of the frame parser test: clock, reset, stimulus, receiver stalls and verdict.
// Depends on ubxnav_pkg, ubx_nav_frame_parser_core and ubx_nav_frame_parser_checker.
`timescale 1ns / 1ps

module ubx_nav_frame_parser_core_test;
    import ubxnav_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        item_valid;
    logic        item_ready;
    in_item_t    item;
    logic        result_valid;
    logic        result_ready;
    out_item_t   result;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [7:0]  cfg_index;
    logic [31:0] cfg_data;

    // Reported by the checker.
    int mismatches;
    int awaiting;
    int frames_seen;
    int sync_errors_seen;

    // Stimulus bookkeeping.
    int words_sent = 0;
    int burst_left = 0;
    int tick_pct = 0;
    bit hold_request = 1'b0;

    ubx_nav_frame_parser_core DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    ubx_nav_frame_parser_checker nav_check (
        .clk              (clk),
        .rst_n            (rst_n),
        .item_valid       (item_valid),
        .item_ready       (item_ready),
        .item             (item),
        .result_valid     (result_valid),
        .result_ready     (result_ready),
        .result           (result),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .mismatches       (mismatches),
        .awaiting         (awaiting),
        .frames_seen      (frames_seen),
        .sync_errors_seen (sync_errors_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // A hard ceiling on the run. The slowest legal run, with every word
    // under heavy receiver stalls and the long hold-off, needs well under
    // a tenth of this.
    initial
    begin
        #2_000_000;
        $display("Timeout: the run did not drain in time.");
        $display("TEST FAILED");
        $finish;
    end

    // Offers one word and waits until it is accepted. All driving happens on
    // the falling edge, and item_ready is sampled on the rising edge. Between
    // words the sender keeps valid high while the burst goes on; once it runs
    // out, the sender mostly drops valid for a random gap.
    task automatic send_word(input logic op, input logic [7:0] b);
        in_item_t w;
        w.operation = op;
        w.rx_byte = b;
        @(negedge clk);
        item_valid <= 1'b1;
        item <= w;
        @(posedge clk);
        while (!item_ready) @(posedge clk);
        words_sent++;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            if ($urandom_range(0, 9) < 7)
            begin
                @(negedge clk);
                item_valid <= 1'b0;
                repeat ($urandom_range(0, 8)) @(negedge clk);
            end
        end
        else burst_left--;
    endtask

    // A received byte, sometimes preceded by a timer tick. Ticks may land
    // anywhere, inside frames too, since they never disturb the parse.
    task automatic send_byte(input logic [7:0] b);
        if ($urandom_range(0, 99) < tick_pct) send_word(OP_TICK, 8'($urandom));
        send_word(OP_BYTE, b);
    endtask

    // A complete frame: sync pair, class, id, little-endian length, payload
    // and two checksum bytes. The checksum is not checked by the block, so
    // it is random. Payload bytes lean toward the extremes now and then so
    // that the captured 32-bit fields hit their signed limits.
    task automatic send_frame(input logic [7:0] cls, input logic [7:0] id, input int len);
        int n;
        int pick;
        send_byte(SYNC_A);
        send_byte(SYNC_B);
        send_byte(cls);
        send_byte(id);
        send_byte(len[7:0]);
        send_byte(len[15:8]);
        for (n = 0; n < len + 2; n++)
        begin
            pick = $urandom_range(0, 9);
            case (pick)
                0:       send_byte(8'h00);
                1:       send_byte(8'hFF);
                2:       send_byte(8'h80);
                default: send_byte(8'($urandom));
            endcase
        end
    endtask

    // A first sync byte followed by anything but the second one. The parser
    // drops it and is hunting again right after, so the next frame is seen.
    task automatic send_broken_sync();
        logic [7:0] b;
        b = 8'($urandom);
        if (b == SYNC_B) b = 8'h00;
        send_byte(SYNC_A);
        send_byte(b);
    endtask

    // Lowers valid and waits until every predicted result word has been
    // taken. Each word yields exactly one result, registered at the edge
    // that accepts it, so the registers are touched only once all are out.
    task automatic wait_idle();
        @(negedge clk);
        item_valid <= 1'b0;
        while (awaiting != 0) @(negedge clk);
        repeat (3) @(negedge clk);
    endtask

    task automatic write_reg(input logic [7:0] idx, input logic [31:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_registers(input logic [15:0] reload, input logic corr,
                                 input logic [31:0] lat_off, input logic [31:0] lon_off);
        wait_idle();
        write_reg(CFG_TIMEOUT_TICKS, {16'd0, reload});
        write_reg(CFG_CORRECTION_ENABLE, {31'd0, corr});
        write_reg(CFG_LAT_OFFSET, lat_off);
        write_reg(CFG_LON_OFFSET, lon_off);
    endtask

    // Random traffic: mostly well-formed NAV frames with random content and
    // the occasional short or overlong payload, plus frames the block skips,
    // line noise, broken sync pairs and tick runs. Noise never leaves the
    // parser inside a frame, so the stream stays in step with later frames.
    task automatic run_traffic(input int budget);
        int         start;
        int         kind;
        int         cnt;
        int         n;
        logic [7:0] b;
        start = words_sent;
        while (words_sent - start < budget)
        begin
            kind = $urandom_range(0, 19);
            if (kind < 5)
                send_frame(CLS_NAV, ID_POSLLH,
                           ($urandom_range(0, 3) == 0) ? $urandom_range(0, 32) : 28);
            else if (kind < 9)
                send_frame(CLS_NAV, ID_VELNED,
                           ($urandom_range(0, 3) == 0) ? $urandom_range(0, 40) : 36);
            else if (kind < 12)
                send_frame(CLS_NAV, ID_STATUS,
                           ($urandom_range(0, 3) == 0) ? $urandom_range(0, 20) : 16);
            else if (kind < 14)
                send_frame(CLS_NAV, 8'($urandom), $urandom_range(0, 24));
            else if (kind < 16)
                send_frame(8'($urandom), 8'($urandom), $urandom_range(0, 24));
            else if (kind < 18)
            begin
                cnt = $urandom_range(1, 5);
                for (n = 0; n < cnt; n++)
                begin
                    b = 8'($urandom);
                    if (b == SYNC_A) send_broken_sync();
                    else send_byte(b);
                end
            end
            else if (kind == 18) send_broken_sync();
            else
            begin
                // A run of ticks alone, to walk the link timeout down.
                cnt = $urandom_range(1, 6);
                for (n = 0; n < cnt; n++) send_word(OP_TICK, 8'($urandom));
            end
        end
    endtask

    // Receiver: stalls on a pattern of its own, changing mode after a random
    // span: always ready, coin flip, mostly stalled, or alternating.
    // When asked, it holds off for a long stretch so that the result
    // register fills and the block has to stall the sender.
    initial
    begin : receiver
        int mode;
        int span;
        int k;
        wait (rst_n === 1'b1);
        forever
        begin
            if (hold_request)
            begin
                hold_request = 1'b0;
                @(negedge clk);
                result_ready <= 1'b0;
                repeat (400) @(negedge clk);
            end
            mode = $urandom_range(0, 3);
            span = $urandom_range(4, 64);
            for (k = 0; k < span; k++)
            begin
                @(negedge clk);
                case (mode)
                    0:       result_ready <= 1'b1;
                    1:       result_ready <= ($urandom_range(0, 1) == 1);
                    2:       result_ready <= ($urandom_range(0, 3) == 0);
                    default: result_ready <= k[0];
                endcase
            end
        end
    end

    // Stimulus and verdict.
    initial
    begin
        rst_n = 1'b0;
        item_valid = 1'b0;
        item = '0;
        result_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        // Directed part under the reset register values. A tick while the
        // link is down, bytes that miss the first sync byte at both ends of
        // the byte range, a miss on the second sync byte, a status frame
        // whose payload just reaches the fix byte, a tick with the link up,
        // and a position frame with an empty payload.
        tick_pct = 0;
        send_word(OP_TICK, 8'hFF);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(SYNC_A);
        send_byte(8'h00);
        send_frame(CLS_NAV, ID_STATUS, 5);
        send_word(OP_TICK, 8'h00);
        send_frame(CLS_NAV, ID_POSLLH, 0);

        // A zero reload drops the link on the first tick after each sync
        // pair. Offsets at the signed extremes check the wrapping subtract.
        set_registers(16'd0, 1'b1, 32'h8000_0000, 32'h7FFF_FFFF);
        tick_pct = 10;
        run_traffic(200);

        // A short timeout with correction off; the long receiver hold-off
        // happens early in this phase while the sender keeps offering.
        set_registers(16'd3, 1'b0, $urandom, $urandom);
        tick_pct = 20;
        hold_request = 1'b1;
        run_traffic(200);

        // Largest reload, then one position frame whose declared length
        // needs both length bytes, which captures its fields early and
        // skips the rest.
        set_registers(16'hFFFF, 1'b1, 32'hFFFF_FFFF, 32'h0000_0001);
        tick_pct = 1;
        send_frame(CLS_NAV, ID_POSLLH, 260);
        tick_pct = 5;
        run_traffic(200);

        // A reload of one with zero offsets.
        set_registers(16'd1, 1'b1, 32'd0, 32'd0);
        tick_pct = 15;
        run_traffic(200);

        // A random small reload and random offsets, with one mid-size frame
        // of a class the block skips.
        set_registers(16'($urandom_range(2, 40)), 1'b1, $urandom, $urandom);
        tick_pct = 10;
        send_frame(8'h0A, 8'($urandom), 300);
        run_traffic(200);

        wait_idle();
        repeat (10) @(negedge clk);

        $display("Covered %0d item words over six register settings: %0d frames completed,",
                 words_sent, frames_seen);
        $display("%0d sync misses flagged, %0d field mismatches.",
                 sync_errors_seen, mismatches);
        if (mismatches == 0 && awaiting == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

### filelist.f
hw/rtl/ubxnav_pkg.sv
hw/rtl/ubxnav_fields.sv
hw/rtl/ubx_nav_frame_parser_core.sv
dv/ubx_nav_frame_parser_checker.sv
dv/ubx_nav_frame_parser_core_test.sv
